[sv/opgpks_pkg.sv]
// Shared types and codes for the OpenPGP key length scanner.
package opgpks_pkg;

  // Parser phase, one-hot
  typedef enum logic [5:0] {
    PH_HEADER     = 6'b000001,
    PH_NEW_FIRST  = 6'b000010,
    PH_TWO_SECOND = 6'b000100,
    PH_LEN_MORE   = 6'b001000,
    PH_BODY       = 6'b010000,
    PH_DONE       = 6'b100000
  } phase_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_ALL_FOUND = 3'd0,
    ST_ENDED     = 3'd1,
    ST_BAD_OLD   = 3'd2,
    ST_BAD_MARK  = 3'd3,
    ST_END_HDR   = 3'd4
  } status_e;

  // Control part of the parser state
  typedef struct packed {
    phase_e     phase;
    logic [5:0] tag;
    logic [2:0] len_left;
    logic       seen_pk;
    logic       seen_uid;
    logic       seen_sig;
  } ctl_t;

  localparam ctl_t CTL_RESET = '{
    phase:    PH_HEADER,
    tag:      6'd0,
    len_left: 3'd0,
    seen_pk:  1'b0,
    seen_uid: 1'b0,
    seen_sig: 1'b0
  };

  // Register indexes on the configuration port (word address bits)
  localparam logic [1:0] REG_TAG_PK  = 2'd0;
  localparam logic [1:0] REG_TAG_UID = 2'd1;
  localparam logic [1:0] REG_TAG_SIG = 2'd2;

  localparam logic [7:0] TWO_BYTE_MIN  = 8'd192;
  localparam logic [7:0] FIVE_BYTE_MIN = 8'd224;
  localparam logic [7:0] FIVE_BYTE_MK  = 8'hFF;

endpackage

[sv/opgpks_parse.sv]
// Per-byte next-state and result logic of the packet header parser.
module opgpks_parse #(
  parameter int OFFSET_BITS = 32
) (
  input  opgpks_pkg::ctl_t        ctl_q_i,
  input  logic [31:0]             accum_q_i,
  input  logic [31:0]             body_q_i,
  input  logic [OFFSET_BITS-1:0]  off_q_i,
  input  logic [OFFSET_BITS-1:0]  hdr_q_i,
  input  logic [7:0]              data_i,
  input  logic                    last_i,
  input  logic [5:0]              tag_pk_i,
  input  logic [5:0]              tag_uid_i,
  input  logic [5:0]              tag_sig_i,
  output opgpks_pkg::ctl_t        ctl_d_o,
  output logic [31:0]             accum_d_o,
  output logic [31:0]             body_d_o,
  output logic [OFFSET_BITS-1:0]  off_d_o,
  output logic [OFFSET_BITS-1:0]  hdr_d_o,
  output logic                    res_valid_o,
  output logic [OFFSET_BITS-1:0]  res_klen_o,
  output opgpks_pkg::status_e     res_status_o
);
  import opgpks_pkg::*;

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

  logic [OFFSET_BITS-1:0] off_inc;
  logic                   hdr_now;
  logic [31:0]            hdr_len;
  logic [31:0]            body_dec;
  logic [31:0]            add_len;
  logic [32:0]            end_sum;
  logic [OFFSET_BITS-1:0] end_val;
  logic                   seen_pk;
  logic                   seen_uid;
  logic                   seen_sig;

  // Saturating offset past the current byte and saturating decrement of the body count
  assign off_inc  = (off_q_i == OFF_MAX) ? off_q_i : off_q_i + OFFSET_BITS'(1);
  assign body_dec = (body_q_i != 32'd0) ? body_q_i - 32'd1 : 32'd0;

  always_comb begin
    ctl_d_o      = ctl_q_i;
    accum_d_o    = accum_q_i;
    body_d_o     = body_q_i;
    off_d_o      = off_q_i;
    hdr_d_o      = hdr_q_i;
    res_valid_o  = 1'b0;
    res_klen_o   = '0;
    res_status_o = ST_ALL_FOUND;
    hdr_now      = 1'b0;
    hdr_len      = 32'd0;
    add_len      = 32'd0;
    end_sum      = 33'd0;
    end_val      = '0;
    seen_pk      = ctl_q_i.seen_pk;
    seen_uid     = ctl_q_i.seen_uid;
    seen_sig     = ctl_q_i.seen_sig;

    if (ctl_q_i.phase == PH_DONE) begin
      // Ignore bytes until the last-byte mark, which rearms
      if (last_i) begin
        ctl_d_o   = CTL_RESET;
        accum_d_o = 32'd0;
        body_d_o  = 32'd0;
        off_d_o   = '0;
        hdr_d_o   = '0;
      end
    end else begin
      off_d_o = off_inc;

      // Advance the header / body walk
      unique case (ctl_q_i.phase)
        PH_HEADER: begin
          hdr_d_o = off_q_i;
          if (data_i[6]) begin
            ctl_d_o.tag   = data_i[5:0];
            ctl_d_o.phase = PH_NEW_FIRST;
          end else begin
            ctl_d_o.tag = {2'b00, data_i[5:2]};
            if (data_i[1:0] == 2'd3) begin
              res_valid_o  = 1'b1;
              res_status_o = ST_BAD_OLD;
              res_klen_o   = off_q_i;
            end else begin
              ctl_d_o.len_left = (data_i[1:0] == 2'd0) ? 3'd1 :
                                 (data_i[1:0] == 2'd1) ? 3'd2 : 3'd4;
              accum_d_o        = 32'd0;
              ctl_d_o.phase    = PH_LEN_MORE;
            end
          end
        end
        PH_NEW_FIRST: begin
          if (data_i < TWO_BYTE_MIN) begin
            hdr_now = 1'b1;
            hdr_len = 32'(data_i);
          end else if (data_i < FIVE_BYTE_MIN) begin
            accum_d_o     = 32'({data_i[4:0], 8'h00});
            ctl_d_o.phase = PH_TWO_SECOND;
          end else if (data_i == FIVE_BYTE_MK) begin
            accum_d_o        = 32'd0;
            ctl_d_o.len_left = 3'd4;
            ctl_d_o.phase    = PH_LEN_MORE;
          end else begin
            res_valid_o  = 1'b1;
            res_status_o = ST_BAD_MARK;
            res_klen_o   = hdr_q_i;
          end
        end
        PH_TWO_SECOND: begin
          hdr_now = 1'b1;
          hdr_len = accum_q_i + 32'(data_i) + 32'(TWO_BYTE_MIN);
        end
        PH_LEN_MORE: begin
          accum_d_o        = {accum_q_i[23:0], data_i};
          ctl_d_o.len_left = ctl_q_i.len_left - 3'd1;
          if (ctl_d_o.len_left == 3'd0) begin
            hdr_now = 1'b1;
            hdr_len = accum_d_o;
          end
        end
        PH_BODY: begin
          body_d_o = body_dec;
          if (!last_i && body_dec == 32'd0) begin
            ctl_d_o.phase = PH_HEADER;
          end
        end
        default: begin
          ctl_d_o = ctl_q_i;
        end
      endcase

      // Saturating end of the packet, shared by header and body paths
      add_len = (ctl_q_i.phase == PH_BODY) ? body_dec : hdr_len;
      end_sum = 33'(off_inc) + {1'b0, add_len};
      end_val = (end_sum > 33'(OFF_MAX)) ? OFF_MAX : end_sum[OFFSET_BITS-1:0];

      if (ctl_q_i.phase == PH_BODY && last_i) begin
        res_valid_o  = 1'b1;
        res_status_o = ST_ENDED;
        res_klen_o   = end_val;
      end

      // Header complete: note the tag, report, or move to the body or the next header
      if (hdr_now) begin
        seen_pk  = seen_pk  | (ctl_d_o.tag == tag_pk_i);
        seen_uid = seen_uid | (ctl_d_o.tag == tag_uid_i);
        seen_sig = seen_sig | (ctl_d_o.tag == tag_sig_i);
        ctl_d_o.seen_pk  = seen_pk;
        ctl_d_o.seen_uid = seen_uid;
        ctl_d_o.seen_sig = seen_sig;
        if (seen_pk && seen_uid && seen_sig) begin
          res_valid_o  = 1'b1;
          res_status_o = ST_ALL_FOUND;
          res_klen_o   = end_val;
        end else if (last_i) begin
          res_valid_o  = 1'b1;
          res_status_o = ST_ENDED;
          res_klen_o   = end_val;
        end else if (hdr_len == 32'd0) begin
          ctl_d_o.phase = PH_HEADER;
        end else begin
          body_d_o      = hdr_len;
          ctl_d_o.phase = PH_BODY;
        end
      end

      // Data ended inside a header
      if (!res_valid_o && last_i) begin
        res_valid_o  = 1'b1;
        res_status_o = ST_END_HDR;
        res_klen_o   = hdr_d_o;
      end

      // After a result: rearm on a marked byte, else hold in done
      if (res_valid_o) begin
        if (last_i) begin
          ctl_d_o   = CTL_RESET;
          accum_d_o = 32'd0;
          body_d_o  = 32'd0;
          off_d_o   = '0;
          hdr_d_o   = '0;
        end else begin
          ctl_d_o.phase = PH_DONE;
        end
      end
    end
  end

endmodule

[sv/openpgp_minimal_key_length_scan.sv]
// Top level: byte stream OpenPGP packet header scanner with APB tag registers.
//
//  channel  | dir | beat contents
//  ---------+-----+----------------------------------------------------
//  s_axis   | in  | tdata[7:0] data_byte, tlast last_byte
//  m_axis   | out | tdata[31:0] key_length, tuser[2:0] status
//  apb      | in  | tag_public_key @0x0, tag_user_id @0x4, tag_signature @0x8
//
// One byte per clock sustained while the output is not stalled; a byte is held in
// the input register, and the result it causes is loaded into the output register.
// The per-byte state update between those registers sets the rate.
// Reset clears the parser state and loads the default tag numbers.
// A stalled output holds its beat and stops the parser; the input register takes
// at most one more byte and holds it until the stalled result is taken.
module openpgp_minimal_key_length_scan #(
  parameter int OFFSET_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input byte stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] key_length
  output logic [2:0]  m_axis_tuser,   // [2:0] status
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import opgpks_pkg::*;

  logic [5:0] tag_pk_q;
  logic [5:0] tag_uid_q;
  logic [5:0] tag_sig_q;
  logic       cfg_wr;

  logic       in_valid_q;
  logic [7:0] in_data_q;
  logic       in_last_q;
  logic       fire;

  ctl_t                   ctl_q, ctl_d;
  logic [31:0]            accum_q, accum_d;
  logic [31:0]            body_q, body_d;
  logic [OFFSET_BITS-1:0] off_q, off_d;
  logic [OFFSET_BITS-1:0] hdr_q, hdr_d;

  logic                   res_valid;
  logic [OFFSET_BITS-1:0] res_klen;
  status_e                res_status;

  logic                   out_valid_q;
  logic [31:0]            out_klen_q;
  status_e                out_status_q;

  // Tag registers
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_pk_q  <= 6'd6;
      tag_uid_q <= 6'd13;
      tag_sig_q <= 6'd2;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_TAG_PK:  tag_pk_q  <= pwdata[5:0];
        REG_TAG_UID: tag_uid_q <= pwdata[5:0];
        REG_TAG_SIG: tag_sig_q <= pwdata[5:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_TAG_PK:  prdata = 32'(tag_pk_q);
      REG_TAG_UID: prdata = 32'(tag_uid_q);
      REG_TAG_SIG: prdata = 32'(tag_sig_q);
      default:     prdata = 32'd0;
    endcase
  end

  // Input register: advance when the output slot frees up
  assign fire          = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  opgpks_parse #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_parse (
    .ctl_q_i      (ctl_q),
    .accum_q_i    (accum_q),
    .body_q_i     (body_q),
    .off_q_i      (off_q),
    .hdr_q_i      (hdr_q),
    .data_i       (in_data_q),
    .last_i       (in_last_q),
    .tag_pk_i     (tag_pk_q),
    .tag_uid_i    (tag_uid_q),
    .tag_sig_i    (tag_sig_q),
    .ctl_d_o      (ctl_d),
    .accum_d_o    (accum_d),
    .body_d_o     (body_d),
    .off_d_o      (off_d),
    .hdr_d_o      (hdr_d),
    .res_valid_o  (res_valid),
    .res_klen_o   (res_klen),
    .res_status_o (res_status)
  );

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q   <= CTL_RESET;
      accum_q <= 32'd0;
      body_q  <= 32'd0;
      off_q   <= '0;
      hdr_q   <= '0;
    end else if (fire) begin
      ctl_q   <= ctl_d;
      accum_q <= accum_d;
      body_q  <= body_d;
      off_q   <= off_d;
      hdr_q   <= hdr_d;
    end
  end

  // Result register: load on a result, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res_valid) begin
      out_klen_q   <= 32'(res_klen);
      out_status_q <= res_status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_klen_q;
  assign m_axis_tuser  = out_status_q;

endmodule

[sv/opgpks_checker.sv]
// Port-level checks for the key length scanner, bound to the top level.
module opgpks_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic [31:0] prdata
);
  import opgpks_pkg::*;

  // A stalled result beat holds its contents
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // Status stays within the defined codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser <= ST_END_HDR)
    else $error("undefined status code");

  // A packet end always lies past at least one byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_ALL_FOUND || m_axis_tuser == ST_ENDED)
      |-> m_axis_tdata != 32'd0)
    else $error("zero packet end offset");

  // No result can appear in the cycle after reset
  assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result right after reset");

  // Tag registers read back six bits only
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    prdata[31:6] == 26'd0)
    else $error("register read has stray upper bits");

endmodule

bind openpgp_minimal_key_length_scan opgpks_checker u_opgpks_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .prdata        (prdata)
);

[test/tb_top.sv]
// Testbench for the OpenPGP key length scanner: byte stream in, key length results out.
module tb_top;
  import opgpks_pkg::*;

  // Spare register address on the configuration port
  localparam logic [1:0] REG_UNUSED  = 2'd3;

  // Old-format length type codes
  localparam logic [1:0] OLD_LEN_1   = 2'd0;
  localparam logic [1:0] OLD_LEN_2   = 2'd1;
  localparam logic [1:0] OLD_LEN_4   = 2'd2;
  localparam logic [1:0] OLD_LEN_BAD = 2'd3;

  localparam int HOLD_CYCLES = 500;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } key_byte_t;

  typedef struct {
    logic [31:0] klen;
    status_e     st;
  } key_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] data_byte
  logic        s_axis_tlast = 1'b0;   // last_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;          // [31:0] key_length
  logic [2:0]  m_axis_tuser;          // [2:0] status
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  openpgp_minimal_key_length_scan dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #6 clk_i = ~clk_i;

  // Scanner copy: tag registers and parser state
  logic [5:0]  tag_pk_q = 6'd6;
  logic [5:0]  tag_uid_q = 6'd13;
  logic [5:0]  tag_sig_q = 6'd2;
  phase_e      scan_ph;
  logic [5:0]  scan_tag;
  logic [2:0]  scan_len_left;
  logic [31:0] scan_len_acc, scan_body_left, scan_off, scan_hdr_start;
  logic        seen_pk, seen_uid, seen_sig;

  key_result_t key_lengths_due[$];
  key_byte_t   byte_q[$];
  key_byte_t   next_beat;
  key_result_t due;

  bit byte_on_bus = 1'b0;
  bit src_gaps_on = 1'b0;
  bit sink_stalls_on = 1'b0;
  bit hold_req = 1'b0;
  int src_gap = 0;
  int sink_stall = 0;
  int hold_left = 0;
  int bytes_queued = 0;
  int bytes_taken = 0;
  int results_seen = 0;
  int error_count = 0;
  int status_tally[5];

  function automatic logic [31:0] sat_offset(input logic [31:0] a, input logic [32:0] b);
    logic [33:0] s;
    s = {2'b00, a} + {1'b0, b};
    return (s > 34'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic void clear_scan();
    scan_ph = PH_HEADER;
    scan_tag = 6'd0;
    scan_len_left = 3'd0;
    scan_len_acc = 32'd0;
    scan_body_left = 32'd0;
    scan_off = 32'd0;
    scan_hdr_start = 32'd0;
    seen_pk = 1'b0;
    seen_uid = 1'b0;
    seen_sig = 1'b0;
  endfunction

  // Close a header: mark its tag, report completion or end, else go to its body or the next header
  function automatic bit header_complete(input logic [31:0] len, input logic [31:0] off,
                                         input bit last, output logic [31:0] klen,
                                         output status_e st);
    klen = sat_offset(off, {1'b0, len});
    st = ST_ALL_FOUND;
    if (scan_tag == tag_pk_q) seen_pk = 1'b1;
    if (scan_tag == tag_uid_q) seen_uid = 1'b1;
    if (scan_tag == tag_sig_q) seen_sig = 1'b1;
    if (seen_pk && seen_uid && seen_sig) return 1'b1;
    if (last) begin
      st = ST_ENDED;
      return 1'b1;
    end
    if (len == 32'd0) begin
      scan_ph = PH_HEADER;
    end else begin
      scan_body_left = len;
      scan_ph = PH_BODY;
    end
    return 1'b0;
  endfunction

  // Advance the scanner by one accepted byte and queue the result it causes
  task automatic scan_key_byte(input logic [7:0] b, input logic last);
    logic [31:0] prev, off, klen;
    status_e     st;
    bit          hit;
    key_result_t r;
    if (scan_ph == PH_DONE) begin
      if (last) clear_scan();
      return;
    end
    prev = scan_off;
    off = sat_offset(scan_off, 33'd1);
    scan_off = off;
    hit = 1'b0;
    klen = 32'd0;
    st = ST_ALL_FOUND;
    case (scan_ph)
      PH_HEADER: begin
        scan_hdr_start = prev;
        if (b[6]) begin
          scan_tag = b[5:0];
          scan_ph = PH_NEW_FIRST;
        end else begin
          scan_tag = {2'b00, b[5:2]};
          if (b[1:0] == OLD_LEN_BAD) begin
            hit = 1'b1;
            st = ST_BAD_OLD;
            klen = scan_hdr_start;
          end else begin
            scan_len_left = (b[1:0] == OLD_LEN_1) ? 3'd1 : (b[1:0] == OLD_LEN_2) ? 3'd2 : 3'd4;
            scan_len_acc = 32'd0;
            scan_ph = PH_LEN_MORE;
          end
        end
      end
      PH_NEW_FIRST: begin
        if (b < TWO_BYTE_MIN) begin
          hit = header_complete({24'd0, b}, off, last, klen, st);
        end else if (b < FIVE_BYTE_MIN) begin
          scan_len_acc = {16'd0, b - TWO_BYTE_MIN, 8'd0};
          scan_ph = PH_TWO_SECOND;
        end else if (b == FIVE_BYTE_MK) begin
          scan_len_acc = 32'd0;
          scan_len_left = 3'd4;
          scan_ph = PH_LEN_MORE;
        end else begin
          hit = 1'b1;
          st = ST_BAD_MARK;
          klen = scan_hdr_start;
        end
      end
      PH_TWO_SECOND: begin
        hit = header_complete(scan_len_acc + {24'd0, b} + 32'd192, off, last, klen, st);
      end
      PH_LEN_MORE: begin
        scan_len_acc = {scan_len_acc[23:0], b};
        scan_len_left = scan_len_left - 3'd1;
        if (scan_len_left == 3'd0) hit = header_complete(scan_len_acc, off, last, klen, st);
      end
      default: begin
        if (scan_body_left != 32'd0) scan_body_left = scan_body_left - 32'd1;
        if (last) begin
          hit = 1'b1;
          st = ST_ENDED;
          klen = sat_offset(off, {1'b0, scan_body_left});
        end else if (scan_body_left == 32'd0) begin
          scan_ph = PH_HEADER;
        end
      end
    endcase
    if (!hit && last) begin
      hit = 1'b1;
      st = ST_END_HDR;
      klen = scan_hdr_start;
    end
    if (!hit) return;
    r.klen = klen;
    r.st = st;
    key_lengths_due.push_back(r);
    if (last) clear_scan();
    else scan_ph = PH_DONE;
  endtask

  // Mostly back-to-back, sometimes a short gap, rarely a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Drive input beats from the pending queue
  always @(negedge clk_i) begin
    if (rst_ni && !byte_on_bus) begin
      if (src_gap > 0) begin
        src_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (byte_q.size() > 0) begin
        next_beat = byte_q.pop_front();
        s_axis_tdata <= next_beat.data;
        s_axis_tlast <= next_beat.last;
        s_axis_tvalid <= 1'b1;
        byte_on_bus = 1'b1;
        src_gap = src_gaps_on ? pick_gap() : 0;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Drive output ready: long hold-off on request, else random stalls
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!sink_stalls_on) begin
      m_axis_tready <= 1'b1;
    end else if (sink_stall > 0) begin
      sink_stall--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      sink_stall = pick_gap();
    end
  end

  // Predict on each accepted byte, then check each result beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        scan_key_byte(s_axis_tdata, s_axis_tlast);
        bytes_taken++;
        byte_on_bus = 1'b0;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (m_axis_tuser <= ST_END_HDR) status_tally[m_axis_tuser]++;
        if (key_lengths_due.size() == 0) begin
          $error("unexpected result: key_length %0d status %0d", m_axis_tdata, m_axis_tuser);
          error_count++;
        end else begin
          due = key_lengths_due.pop_front();
          if (m_axis_tdata !== due.klen) begin
            $error("key_length mismatch: expected %0d, got %0d", due.klen, m_axis_tdata);
            error_count++;
          end
          if (m_axis_tuser !== 3'(due.st)) begin
            $error("status mismatch: expected %0d, got %0d", due.st, m_axis_tuser);
            error_count++;
          end
        end
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic last);
    key_byte_t kb;
    kb.data = b;
    kb.last = last;
    byte_q.push_back(kb);
    bytes_queued++;
  endtask

  // Build one key: mostly packet sequences, some broken or cut, some noise
  task automatic queue_random_key();
    logic [7:0]  kb[$];
    logic [5:0]  tag;
    logic [31:0] len, len2;
    logic        b7;
    int          kind, blen, form, cut;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      repeat ($urandom_range(1, 8)) kb.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 4))
          0: tag = tag_pk_q;
          1: tag = tag_uid_q;
          2: tag = tag_sig_q;
          default: tag = 6'($urandom_range(0, 63));
        endcase
        b7 = 1'($urandom_range(0, 1));
        form = $urandom_range(0, 5);
        blen = $urandom_range(0, 12);
        if (form == 1 || $urandom_range(0, 29) == 0) blen = $urandom_range(192, 240);
        if (form == 0 && blen >= 192) form = 2;
        len = 32'(blen);
        // now and then announce a huge body that the key never delivers
        if (form == 2 && $urandom_range(0, 19) == 0) len = $urandom() | 32'h8000_0000;
        len2 = len - 32'd192;
        case (form)
          0: begin
            kb.push_back({b7, 1'b1, tag});
            kb.push_back(len[7:0]);
          end
          1: begin
            kb.push_back({b7, 1'b1, tag});
            kb.push_back(TWO_BYTE_MIN + len2[15:8]);
            kb.push_back(len2[7:0]);
          end
          2: begin
            kb.push_back({b7, 1'b1, tag});
            kb.push_back(FIVE_BYTE_MK);
            kb.push_back(len[31:24]);
            kb.push_back(len[23:16]);
            kb.push_back(len[15:8]);
            kb.push_back(len[7:0]);
          end
          3: begin
            kb.push_back({b7, 1'b0, tag[3:0], OLD_LEN_1});
            kb.push_back(len[7:0]);
          end
          4: begin
            kb.push_back({b7, 1'b0, tag[3:0], OLD_LEN_2});
            kb.push_back(len[15:8]);
            kb.push_back(len[7:0]);
          end
          default: begin
            kb.push_back({b7, 1'b0, tag[3:0], OLD_LEN_4});
            kb.push_back(len[31:24]);
            kb.push_back(len[23:16]);
            kb.push_back(len[15:8]);
            kb.push_back(len[7:0]);
          end
        endcase
        repeat (blen) kb.push_back(8'($urandom_range(0, 255)));
      end
      // append a broken header to some keys
      if (kind < 30) begin
        b7 = 1'($urandom_range(0, 1));
        tag = 6'($urandom_range(0, 63));
        if ($urandom_range(0, 1) == 0) begin
          kb.push_back({b7, 1'b0, tag[3:0], OLD_LEN_BAD});
        end else begin
          kb.push_back({b7, 1'b1, tag});
          kb.push_back(8'($urandom_range(224, 254)));
        end
      end
      // cut some keys short, give others trailing bytes
      if ($urandom_range(0, 3) == 0) begin
        cut = $urandom_range(1, kb.size());
        while (kb.size() > cut) void'(kb.pop_back());
      end else if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 6)) kb.push_back(8'($urandom_range(0, 255)));
      end
    end
    foreach (kb[i]) push_byte(kb[i], i == kb.size() - 1);
  endtask

  task automatic queue_random_keys(input int budget);
    int target;
    target = bytes_queued + budget;
    while (bytes_queued < target) queue_random_key();
  endtask

  // Wait until every byte is taken and every result is back, then let the pipe settle
  task automatic wait_drained();
    while (byte_q.size() != 0 || byte_on_bus || key_lengths_due.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_tag_reg(input logic [1:0] idx, input logic [5:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= ($urandom() & 32'hFFFF_FFC0) | {26'd0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_TAG_PK:  tag_pk_q = val;
      REG_TAG_UID: tag_uid_q = val;
      REG_TAG_SIG: tag_sig_q = val;
      default: ;
    endcase
  endtask

  task automatic write_tags(input logic [5:0] pk, input logic [5:0] uid, input logic [5:0] sig);
    write_tag_reg(REG_TAG_PK, pk);
    write_tag_reg(REG_TAG_UID, uid);
    write_tag_reg(REG_TAG_SIG, sig);
  endtask

  initial begin
    clear_scan();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed keys under the default tags
    push_byte(8'h03, 1'b1);                       // old length type 3 on the last byte
    push_byte(8'hC6, 1'b0);                       // bad five-byte marker, then ignored
    push_byte(8'hFE, 1'b0);
    push_byte(8'h34, 1'b1);
    push_byte(8'hC6, 1'b0);                       // public key, empty body
    push_byte(8'h00, 1'b0);
    push_byte(8'hCD, 1'b0);                       // user id, one body byte
    push_byte(8'h01, 1'b0);
    push_byte(8'hAA, 1'b0);
    push_byte(8'h88, 1'b0);                       // old signature header completes on last
    push_byte(8'h02, 1'b1);
    push_byte(8'h85, 1'b1);                       // end inside an old header
    push_byte(8'hC2, 1'b0);                       // five-byte length of all ones
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h19, 1'b0);                       // old two-byte length, end in body
    push_byte(8'h00, 1'b0);
    push_byte(8'h05, 1'b0);
    push_byte(8'h01, 1'b1);
    push_byte(8'hFF, 1'b0);                       // tag 63, largest two-byte first octet
    push_byte(8'hDF, 1'b0);
    push_byte(8'h00, 1'b1);
    queue_random_keys(340);
    wait_drained();

    // Extreme tags, one spare address write, idling on both sides
    write_tags(6'd63, 6'd0, 6'd63);
    write_tag_reg(REG_UNUSED, 6'd5);
    src_gaps_on = 1'b1;
    sink_stalls_on = 1'b1;
    queue_random_keys(340);
    wait_drained();

    // All three roles on one tag
    write_tags(6'd0, 6'd0, 6'd0);
    queue_random_keys(340);
    wait_drained();

    // Random tags, sender at full rate
    write_tags(6'($urandom_range(0, 15)), 6'($urandom_range(0, 63)),
               6'($urandom_range(0, 15)));
    src_gaps_on = 1'b0;
    queue_random_keys(340);
    wait_drained();

    // Tags at the edge of the old-format range
    write_tags(6'd15, 6'd1, 6'd8);
    src_gaps_on = 1'b1;
    queue_random_keys(340);
    wait_drained();

    // Hold the output off while one-result keys keep coming
    src_gaps_on = 1'b0;
    sink_stalls_on = 1'b0;
    hold_req = 1'b1;
    repeat (30) begin
      push_byte(8'h03, 1'b1);
      push_byte({1'b1, 1'b1, 6'($urandom_range(0, 63))}, 1'b0);
      push_byte(8'($urandom_range(224, 254)), 1'b1);
    end
    wait_drained();
    repeat (8) @(posedge clk_i);

    if (key_lengths_due.size() != 0) begin
      $error("%0d expected results never arrived", key_lengths_due.size());
      error_count++;
    end
    $display("Covered %0d key bytes and %0d results over five tag settings and a hold-off.",
             bytes_taken, results_seen);
    $display("Statuses: all found %0d, ended %0d, bad old %0d, bad marker %0d, in header %0d",
             status_tally[ST_ALL_FOUND], status_tally[ST_ENDED], status_tally[ST_BAD_OLD],
             status_tally[ST_BAD_MARK], status_tally[ST_END_HDR]);
    if (error_count == 0) begin
      $display("openpgp_minimal_key_length_scan verification clean");
    end else begin
      $display("openpgp_minimal_key_length_scan verification failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #12000000;
    $display("openpgp_minimal_key_length_scan verification failed");
    $finish;
  end

endmodule
